// ----- design/thk_pkg.sv -----
package thk_pkg;

  localparam int PENDING_DEPTH = 8;
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
  localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // result action codes
  localparam logic [2:0] ACT_PASS      = 3'd0;
  localparam logic [2:0] ACT_ABSORB    = 3'd1;
  localparam logic [2:0] ACT_PRESS     = 3'd2;
  localparam logic [2:0] ACT_RELEASE   = 3'd3;
  localparam logic [2:0] ACT_LAYER_ON  = 3'd4;
  localparam logic [2:0] ACT_LAYER_OFF = 3'd5;
  localparam logic [2:0] ACT_MODS_ON   = 3'd6;
  localparam logic [2:0] ACT_MODS_OFF  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] REG_HOLD_LIMIT    = 2'd0;
  localparam logic [1:0] REG_TARGET_LAYER  = 2'd1;
  localparam logic [1:0] REG_HOLD_MOD_MASK = 2'd2;
  localparam logic [1:0] REG_TAP_CODE      = 2'd3;

  typedef struct packed {
    logic        kind;
    logic        pressed;
    logic [15:0] key_code;
    logic [15:0] event_time;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] hold_limit;
    logic [4:0]  target_layer;
    logic [7:0]  hold_mod_mask;
    logic [15:0] tap_code;
  } cfg_t;

  typedef struct packed {
    logic        down;
    logic [15:0] code;
  } pend_t;

  // what the back end has to do for one event
  typedef enum logic [2:0] {
    OP_PASS       = 3'd0,
    OP_ABSORB     = 3'd1,
    OP_DUAL_PRESS = 3'd2,
    OP_TAP        = 3'd3,
    OP_TAP_REPLAY = 3'd4,
    OP_REPLAY_REL = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        key;
    logic [PEND_CW-1:0] rcnt;
  } cmd_t;

  typedef struct packed {
    logic               rep_done;
    logic [PEND_AW-1:0] rd_addr;
  } bk2fr_t;

endpackage

// ----- design/thk_cmd_fifo.sv -----
module thk_cmd_fifo import thk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      if (wr && !rd) count <= count + 2'd1;
      else if (rd && !wr) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

endmodule

// ----- design/thk_front.sv -----
module thk_front import thk_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  item_t  item,
  input  logic   push,
  output logic   full,
  output logic   cmd_push,
  output cmd_t   cmd,
  input  logic   cmd_full,
  input  bk2fr_t bk,
  output pend_t  rd_data,
  output logic   repl_busy
);

  pend_t              mem [PENDING_DEPTH];
  logic [15:0]        hold_start_time;
  logic               hold_active;
  logic               was_interrupted;
  logic [PEND_CW-1:0] pending_count;
  logic               has_release;

  logic        accept;
  logic [15:0] elapsed;
  logic        clear_buf;
  logic        buffer_it;

  // a replay reads the buffer, so no new event until it is out
  assign full     = cmd_full || repl_busy;
  assign accept   = push && !full;
  assign cmd_push = accept;
  assign elapsed  = item.event_time - hold_start_time;

  always_comb begin
    cmd.key   = item.key_code;
    cmd.op    = OP_PASS;
    cmd.rcnt  = '0;
    clear_buf = 1'b0;
    buffer_it = 1'b0;
    if (!item.kind) begin
      if (!hold_active) begin
        cmd.op = OP_PASS;
      end else if (elapsed > cfg.hold_limit) begin
        cmd.op    = OP_PASS;
        cmd.rcnt  = pending_count;
        clear_buf = 1'b1;
      end else begin
        cmd.op    = OP_ABSORB;
        buffer_it = (pending_count < PEND_CW'(PENDING_DEPTH));
      end
    end else if (item.pressed) begin
      cmd.op = OP_DUAL_PRESS;
    end else if (elapsed < cfg.hold_limit) begin
      if (!was_interrupted) begin
        cmd.op = OP_TAP;
      end else if (has_release) begin
        cmd.op    = OP_REPLAY_REL;
        cmd.rcnt  = pending_count;
        clear_buf = 1'b1;
      end else begin
        cmd.op    = OP_TAP_REPLAY;
        cmd.rcnt  = pending_count;
        clear_buf = 1'b1;
      end
    end else begin
      cmd.op    = OP_REPLAY_REL;
      cmd.rcnt  = pending_count;
      clear_buf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_start_time <= '0;
      hold_active     <= 1'b0;
      was_interrupted <= 1'b0;
      pending_count   <= '0;
      has_release     <= 1'b0;
      repl_busy       <= 1'b0;
    end else begin
      if (bk.rep_done) repl_busy <= 1'b0;
      if (accept) begin
        if (cmd.rcnt != '0) repl_busy <= 1'b1;
        if (clear_buf) begin
          pending_count <= '0;
          has_release   <= 1'b0;
        end
        if (buffer_it) begin
          pending_count <= pending_count + PEND_CW'(1);
          if (!item.pressed) has_release <= 1'b1;
        end
        if (!item.kind) begin
          if (hold_active && !(elapsed > cfg.hold_limit)) was_interrupted <= 1'b1;
        end else if (item.pressed) begin
          hold_start_time <= item.event_time;
          hold_active     <= 1'b1;
          was_interrupted <= 1'b0;
        end else begin
          hold_active <= 1'b0;
        end
      end
    end
  end

  // rd_addr is the entry the back end wants in the next cycle
  always_ff @(posedge clk) begin
    if (accept && buffer_it) begin
      mem[pending_count[PEND_AW-1:0]] <= '{down: item.pressed, code: item.key_code};
    end
    rd_data <= mem[bk.rd_addr];
  end

endmodule

// ----- design/thk_back.sv -----
module thk_back import thk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  output bk2fr_t  bk,
  input  pend_t   rd_data,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_REP_PRE   = 11'b00000000010,
    S_PASS      = 11'b00000000100,
    S_ABSORB    = 11'b00000001000,
    S_LAYER_ON  = 11'b00000010000,
    S_MODS_ON   = 11'b00000100000,
    S_MODS_OFF  = 11'b00001000000,
    S_LAYER_OFF = 11'b00010000000,
    S_TAP_PRESS = 11'b00100000000,
    S_TAP_REL   = 11'b01000000000,
    S_REP_POST  = 11'b10000000000
  } state_t;

  state_t             state;
  state_t             state_next;
  state_t             first_state;
  cmd_t               cur;
  logic [PEND_CW-1:0] ridx;
  logic [PEND_CW-1:0] ridx_next;
  logic               rep_last;
  logic               out_valid;
  result_t            out_data;
  logic               slot_free;
  logic               emit;
  result_t            res;

  assign slot_free = !out_valid || pop;
  assign emit      = (state != S_IDLE) && slot_free;
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign rep_last  = (ridx == cur.rcnt - PEND_CW'(1));
  assign bk.rd_addr  = ridx_next[PEND_AW-1:0];
  assign bk.rep_done = emit && rep_last && ((state == S_REP_PRE) || (state == S_REP_POST));
  assign result = out_data;
  assign empty  = !out_valid;

  always_comb begin
    ridx_next = ridx;
    if (state == S_IDLE) begin
      ridx_next = '0;
    end else if (emit && ((state == S_REP_PRE) || (state == S_REP_POST))) begin
      ridx_next = rep_last ? '0 : ridx + PEND_CW'(1);
    end
  end

  always_comb begin
    case (cmd.op)
      OP_PASS:       first_state = (cmd.rcnt != '0) ? S_REP_PRE : S_PASS;
      OP_ABSORB:     first_state = S_ABSORB;
      OP_DUAL_PRESS: first_state = S_LAYER_ON;
      OP_REPLAY_REL: first_state = (cmd.rcnt != '0) ? S_REP_PRE : S_MODS_OFF;
      default:       first_state = S_MODS_OFF;
    endcase
  end

  always_comb begin
    res.action = ACT_PASS;
    res.code   = cur.key;
    res.last   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!cmd_empty) state_next = first_state;
      end
      S_REP_PRE: begin
        res.action = rd_data.down ? ACT_PRESS : ACT_RELEASE;
        res.code   = rd_data.code;
        if (rep_last) state_next = (cur.op == OP_PASS) ? S_PASS : S_MODS_OFF;
      end
      S_PASS: begin
        res.action = ACT_PASS;
        res.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_ABSORB: begin
        res.action = ACT_ABSORB;
        res.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_LAYER_ON: begin
        res.action = ACT_LAYER_ON;
        res.code   = {11'd0, cfg.target_layer};
        state_next = S_MODS_ON;
      end
      S_MODS_ON: begin
        res.action = ACT_MODS_ON;
        res.code   = {8'd0, cfg.hold_mod_mask};
        res.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_MODS_OFF: begin
        res.action = ACT_MODS_OFF;
        res.code   = {8'd0, cfg.hold_mod_mask};
        state_next = S_LAYER_OFF;
      end
      S_LAYER_OFF: begin
        res.action = ACT_LAYER_OFF;
        res.code   = {11'd0, cfg.target_layer};
        if (cur.op == OP_REPLAY_REL) begin
          res.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_TAP_PRESS;
        end
      end
      S_TAP_PRESS: begin
        res.action = ACT_PRESS;
        res.code   = cfg.tap_code;
        state_next = S_TAP_REL;
      end
      S_TAP_REL: begin
        res.action = ACT_RELEASE;
        res.code   = cfg.tap_code;
        if ((cur.op == OP_TAP_REPLAY) && (cur.rcnt != '0)) begin
          state_next = S_REP_POST;
        end else begin
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REP_POST: begin
        res.action = rd_data.down ? ACT_PRESS : ACT_RELEASE;
        res.code   = rd_data.code;
        if (rep_last) begin
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ridx      <= '0;
      out_valid <= 1'b0;
    end else begin
      ridx <= ridx_next;
      if ((state == S_IDLE) || emit) state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur <= cmd;
    if (emit) out_data <= res;
  end

endmodule

// ----- design/tap_hold_key_resolver.sv -----
// Tap/hold resolver for one dual-role key. Events are pushed while full is low
// and results come out oldest first while empty is low. The front end takes one
// event per cycle while full is low and queues a command; the back end picks up a
// command while idle, then emits one result per cycle while its output slot is
// free. An event that replays the pending buffer holds full high until the last
// buffered entry has been emitted, since the buffer has a single owner at a time.
// No clearing pass after reset.
module tap_hold_key_resolver import thk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        push,
  output logic        full,
  output result_t     result,
  output logic        empty,
  input  logic        pop,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  cfg_t   cfg;
  logic   cmd_push;
  cmd_t   cmd_in;
  logic   cmd_full;
  logic   cmd_pop;
  cmd_t   cmd_out;
  logic   cmd_empty;
  bk2fr_t bk;
  pend_t  rd_data;
  logic   repl_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_limit    <= 16'd200;
      cfg.target_layer  <= 5'd1;
      cfg.hold_mod_mask <= 8'd1;
      cfg.tap_code      <= 16'd4;
    end else if (wr_en) begin
      case (wr_index)
        REG_HOLD_LIMIT:    cfg.hold_limit    <= wr_data;
        REG_TARGET_LAYER:  cfg.target_layer  <= wr_data[4:0];
        REG_HOLD_MOD_MASK: cfg.hold_mod_mask <= wr_data[7:0];
        REG_TAP_CODE:      cfg.tap_code      <= wr_data;
        default: ;
      endcase
    end
  end

  thk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .push      (push),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full),
    .bk        (bk),
    .rd_data   (rd_data),
    .repl_busy (repl_busy)
  );

  thk_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  thk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .bk        (bk),
    .rd_data   (rd_data),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  a_no_cmd_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_full))
    else $error("command queue written while full");

  a_no_cmd_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command queue read while empty");

  a_replay_owned: assert property (@(posedge clk) disable iff (rst)
    bk.rep_done |-> repl_busy)
    else $error("replay finished with no replay outstanding");

endmodule
